>>> rtl/scca_pkg.sv
// ----------------------------------------------------------------------------
// scca_pkg: shared constants and types for the seam cost column accumulator
// Field widths, fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package scca_pkg;

  // Map geometry
  localparam int MAX_ROWS_DEFAULT = 1024;

  // Beat field widths
  localparam int DIST_W     = 8;
  localparam int COST_W     = 29;
  localparam int ROWS_CFG_W = 11;
  localparam int WEIGHT_W   = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_WEIGHT = 2'd1;

  localparam int ROWS_RESET   = 1024;
  localparam int WEIGHT_RESET = 179;
  localparam int WEIGHT_ONE   = 256;

  // Fixed point: Q.8 costs, cap of 10000.0, low saturation bound
  localparam int FRAC_BITS = 8;
  localparam int COST_CAP  = 10000 * 256;
  localparam int COST_LOW  = -(1 << 28);

  typedef logic signed [COST_W-1:0] cost_t;
  typedef logic signed [DIST_W-1:0] dist_t;

endpackage

>>> rtl/scca_cfg_if.sv
// ----------------------------------------------------------------------------
// scca_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface scca_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [scca_pkg::CFG_IDX_W-1:0]     index;
  logic [scca_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/scca_in_if.sv
// ----------------------------------------------------------------------------
// scca_in_if: pixel input channel
// One beat carries one distance-map pixel and the start-of-map mark.
// ----------------------------------------------------------------------------
interface scca_in_if;
  logic                  valid;
  logic                  ready;
  scca_pkg::dist_t       dist_value;
  logic                  start_of_map;

  modport source (output valid, dist_value, start_of_map, input ready);
  modport sink   (input valid, dist_value, start_of_map, output ready);
endinterface

>>> rtl/scca_out_if.sv
// ----------------------------------------------------------------------------
// scca_out_if: cost output channel
// One beat carries the accumulated cost of one pixel.
// ----------------------------------------------------------------------------
interface scca_out_if;
  logic                  valid;
  logic                  ready;
  scca_pkg::cost_t       cost;
  logic                  column_end;

  modport source (output valid, cost, column_end, input ready);
  modport sink   (input valid, cost, column_end, output ready);
endinterface

>>> rtl/seam_cost_column_accumulator.sv
// ----------------------------------------------------------------------------
// Pipeline: RAM read, multiply stage, min/add stage into the output register.
// Throughput: one pixel per cycle unless the output channel holds off; with 2
// or 3 rows per column the read-after-write interlock on the cost RAM also
// holds input back. Reset: empties the pipeline, row 0 of a first column,
// rows 1024, weight 179. Cost RAM contents are not cleared.
// ----------------------------------------------------------------------------
// seam_cost_column_accumulator
// Cumulative seam cost, one column at a time. Previous and current column
// costs live in two banks of one RAM that swap at each column end; a
// two-entry window plus the RAM read of row r+1 supplies the three terms.
// ----------------------------------------------------------------------------
module seam_cost_column_accumulator #(
  parameter int MAX_ROWS = scca_pkg::MAX_ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  scca_cfg_if.sink          cfg,
  scca_in_if.sink           pixels,
  scca_out_if.source        costs
);

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = (RW + 1 > scca_pkg::ROWS_CFG_W) ? RW + 1 : scca_pkg::ROWS_CFG_W;
  localparam int RAM_AW    = RW + 1;
  localparam int RAM_DEPTH = 2 * (1 << RW);
  localparam int PW        = scca_pkg::COST_W + scca_pkg::WEIGHT_W + 1;
  localparam int WW        = PW - scca_pkg::FRAC_BITS;
  localparam int SW        = WW + 1;
  localparam int ROWS_INIT = (scca_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS
                                                               : scca_pkg::ROWS_RESET;

  // Configuration registers, stored already clamped
  logic [RW-1:0]                  last_row, last_row_next;
  logic [scca_pkg::WEIGHT_W-1:0]  weight, weight_next;
  logic [CW-1:0]                  rows_req, rows_clamped;
  logic [scca_pkg::WEIGHT_W-1:0]  weight_req;

  // Column walk
  logic [RW-1:0] row_position;
  logic          in_first_column;
  logic          bank;

  // Handshake
  logic out_valid, s1_valid, s2_valid;
  logic out_free, s1_free, s2_free, s1_go, s2_go;
  logic accept, hazard, need_ahead;
  logic [RW-1:0] ahead_row;

  // Accept stage
  logic          start;
  logic [RW-1:0] acc_row;
  logic          acc_first, acc_last;

  // RAM
  logic [RAM_AW-1:0]             ram_waddr, ram_raddr;
  logic [scca_pkg::COST_W-1:0]   ram_rdata;

  // Stage 1
  scca_pkg::dist_t        s1_d;
  logic [RW-1:0]          s1_row;
  logic                   s1_first, s1_last, s1_bank;
  scca_pkg::cost_t        win_up, win_mid, row0_cost;
  scca_pkg::cost_t        p_mid, p_dn, m0;
  logic signed [PW-1:0]   prod_up, prod_dn;
  logic signed [scca_pkg::WEIGHT_W:0] w_s;

  // Stage 2
  scca_pkg::dist_t        s2_d;
  logic [RW-1:0]          s2_row;
  logic                   s2_first, s2_last, s2_bank;
  logic signed [PW-1:0]   s2_prod_up, s2_prod_dn;
  scca_pkg::cost_t        s2_m0;
  logic signed [WW-1:0]   wt_up, wt_dn, m_sel;
  logic signed [SW-1:0]   sum;
  scca_pkg::cost_t        cost_next;

  // Output register
  scca_pkg::cost_t out_cost;
  logic            out_end;

  // --------------------------------------------------------------------------
  // Configuration: clamp on write
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_comb begin
    rows_req   = CW'(cfg.data[scca_pkg::ROWS_CFG_W-1:0]);
    weight_req = cfg.data[scca_pkg::WEIGHT_W-1:0];
    if (rows_req < CW'(2)) begin
      rows_clamped = CW'(2);
    end else if (rows_req > CW'(MAX_ROWS)) begin
      rows_clamped = CW'(MAX_ROWS);
    end else begin
      rows_clamped = rows_req;
    end
    last_row_next = RW'(rows_clamped - CW'(1));
    if (weight_req > scca_pkg::WEIGHT_W'(scca_pkg::WEIGHT_ONE)) begin
      weight_next = scca_pkg::WEIGHT_W'(scca_pkg::WEIGHT_ONE);
    end else begin
      weight_next = weight_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= RW'(ROWS_INIT - 1);
      weight   <= scca_pkg::WEIGHT_W'(scca_pkg::WEIGHT_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        scca_pkg::REG_ROWS_IN_USE:      last_row <= last_row_next;
        scca_pkg::REG_NEIGHBOUR_WEIGHT: weight   <= weight_next;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  assign out_free = !out_valid || costs.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_go    = s1_valid && s2_free;
  assign s2_go    = s2_valid && out_free;

  // Interlock: row r+1 of the previous column still in flight (short columns)
  assign ahead_row  = row_position + RW'(1);
  assign need_ahead = !in_first_column && (row_position < last_row);
  assign hazard = need_ahead &&
                  ((s1_valid && (s1_bank != bank) && (s1_row == ahead_row)) ||
                   (s2_valid && (s2_bank != bank) && (s2_row == ahead_row)));

  assign pixels.ready = s1_free && !hazard;
  assign accept       = pixels.valid && pixels.ready;

  // --------------------------------------------------------------------------
  // Accept: row tracking and RAM read of the next row
  // --------------------------------------------------------------------------
  assign start     = pixels.start_of_map;
  assign acc_row   = start ? '0 : row_position;
  assign acc_first = start || in_first_column;
  assign acc_last  = (acc_row >= last_row);
  assign ram_raddr = {~bank, acc_row + RW'(1)};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      in_first_column <= 1'b1;
      bank            <= 1'b0;
    end else if (accept) begin
      if (acc_last) begin
        row_position    <= '0;
        in_first_column <= 1'b0;
        bank            <= ~bank;
      end else begin
        row_position    <= acc_row + RW'(1);
        in_first_column <= acc_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_d     <= pixels.dist_value;
      s1_row   <= acc_row;
      s1_first <= acc_first;
      s1_last  <= acc_last;
      s1_bank  <= bank;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: neighbor window, weight multiplies, cap of the center term
  // --------------------------------------------------------------------------
  assign p_mid   = (s1_row == '0) ? row0_cost : win_mid;
  assign p_dn    = scca_pkg::cost_t'(ram_rdata);
  assign w_s     = $signed({1'b0, weight});
  assign prod_up = PW'(win_up) * PW'(w_s);
  assign prod_dn = PW'(p_dn) * PW'(w_s);
  assign m0      = (p_mid < scca_pkg::COST_W'(scca_pkg::COST_CAP)) ? p_mid
                                                                  : scca_pkg::COST_W'(scca_pkg::COST_CAP);

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_up  <= p_mid;
      win_mid <= p_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_d       <= s1_d;
      s2_row     <= s1_row;
      s2_first   <= s1_first;
      s2_last    <= s1_last;
      s2_bank    <= s1_bank;
      s2_prod_up <= prod_up;
      s2_prod_dn <= prod_dn;
      s2_m0      <= m0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: floor shift, edge-aware minimum, add 2*d (d alone in a first column), low saturation
  // --------------------------------------------------------------------------
  assign wt_up = WW'(s2_prod_up >>> scca_pkg::FRAC_BITS);
  assign wt_dn = WW'(s2_prod_dn >>> scca_pkg::FRAC_BITS);

  always_comb begin
    m_sel = WW'(s2_m0);
    if ((s2_row != '0) && (wt_up < m_sel)) begin
      m_sel = wt_up;
    end
    if (!s2_last && (wt_dn < m_sel)) begin
      m_sel = wt_dn;
    end
    if (s2_first) begin
      sum = SW'(s2_d) <<< scca_pkg::FRAC_BITS;
    end else begin
      sum = (SW'(s2_d) <<< (scca_pkg::FRAC_BITS + 1)) + SW'(m_sel);
    end
    if (sum < SW'(scca_pkg::COST_LOW)) begin
      cost_next = scca_pkg::COST_W'(scca_pkg::COST_LOW);
    end else begin
      cost_next = scca_pkg::COST_W'(sum);
    end
  end

  // Row 0 of the latest column, used as prev[0] by the next column
  always_ff @(posedge clk) begin
    if (s2_go && (s2_row == '0)) begin
      row0_cost <= cost_next;
    end
  end

  assign ram_waddr = {s2_bank, s2_row};

  scca_ram #(
    .WIDTH (scca_pkg::COST_W),
    .DEPTH (RAM_DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (s2_go),
    .waddr (ram_waddr),
    .wdata (cost_next),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_cost <= cost_next;
      out_end  <= s2_last;
    end
  end

  assign costs.valid      = out_valid;
  assign costs.cost       = out_cost;
  assign costs.column_end = out_end;

endmodule

>>> rtl/scca_ram.sv
// ----------------------------------------------------------------------------
// scca_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// Read data holds while re is low.
// ----------------------------------------------------------------------------
module scca_ram #(
  parameter int WIDTH = scca_pkg::COST_W,
  parameter int DEPTH = 2 * scca_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the seam cost column accumulator
// Streams distance-map pixels through the block and checks every cost beat
// against an in-bench predictor of the column recurrence. The run covers
// several row-count and weight settings, including out-of-range values.
// It also covers a row count shrunk mid-column, start marks mid-column,
// a full-height column and the 10000.0 cap, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int ROW_LIMIT = scca_pkg::MAX_ROWS_DEFAULT;

  typedef struct packed {
    scca_pkg::dist_t dval;
    logic            som;
  } pixel_beat_t;

  typedef struct {
    scca_pkg::cost_t cost;
    logic            column_end;
  } cost_beat_t;

  typedef enum int {SENDER_LIGHT, RECEIVER_LIGHT, NO_IDLE} idle_mode_t;

  logic clk;
  logic rst;

  scca_cfg_if cfg_bus ();
  scca_in_if  pix_bus ();
  scca_out_if cost_bus ();

  seam_cost_column_accumulator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixels (pix_bus),
    .costs  (cost_bus)
  );

  // Pixels waiting to be driven, costs waiting to be seen
  pixel_beat_t pending_pixels[$];
  cost_beat_t  expected_costs[$];
  int pixels_queued = 0;
  int pixels_accepted = 0;
  int error_count = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 49;

  // Predictor state
  longint prev_col[ROW_LIMIT];
  longint cur_col[ROW_LIMIT];
  int     row_pos = 0;
  bit     first_col = 1'b1;
  int     rows_eff = scca_pkg::ROWS_RESET;
  longint weight_eff = longint'(scca_pkg::WEIGHT_RESET);

  // Stimulus-side view of the column position, to keep reads on written rows
  int gen_pos = 0;
  bit gen_first = 1'b1;
  int gen_rows = scca_pkg::ROWS_RESET;
  bit need_start = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rows_effective(input logic [scca_pkg::CFG_DATA_W-1:0] value);
    if (value < 2) return 2;
    if (value > ROW_LIMIT) return ROW_LIMIT;
    return int'(value);
  endfunction

  // Neighbour term: Q.8 product, floor on the shift
  function automatic longint scale_neighbour(input longint c);
    longint p;
    p = c * weight_eff;
    return p >>> scca_pkg::FRAC_BITS;
  endfunction

  // Cost of one pixel; advances row and column state
  function automatic cost_beat_t predict_cost(input scca_pkg::dist_t d, input logic som);
    int         r;
    logic       last;
    longint     c;
    longint     m;
    longint     t;
    cost_beat_t e;
    if (som) begin
      row_pos = 0;
      first_col = 1'b1;
    end
    r = row_pos;
    last = (r >= rows_eff - 1);
    if (r >= ROW_LIMIT) r = ROW_LIMIT - 1;
    if (first_col) begin
      c = longint'(d) * 256;
    end else begin
      m = (prev_col[r] < longint'(scca_pkg::COST_CAP)) ? prev_col[r]
                                                       : longint'(scca_pkg::COST_CAP);
      if (r == 0) begin
        t = scale_neighbour(prev_col[1]);
        if (t < m) m = t;
      end else begin
        t = scale_neighbour(prev_col[r-1]);
        if (t < m) m = t;
        if (!last) begin
          t = scale_neighbour(prev_col[r+1]);
          if (t < m) m = t;
        end
      end
      c = 2 * longint'(d) * 256 + m;
    end
    if (c < longint'(scca_pkg::COST_LOW)) c = longint'(scca_pkg::COST_LOW);
    cur_col[r] = c;
    e.cost = scca_pkg::cost_t'(c);
    e.column_end = last;
    if (last) begin
      prev_col = cur_col;
      first_col = 1'b0;
      row_pos = 0;
    end else begin
      row_pos = r + 1;
    end
    return e;
  endfunction

  // Pixel driver
  always @(posedge clk) begin : pixel_driver
    pixel_beat_t beat;
    if (rst) begin
      pix_bus.valid        <= 1'b0;
      pix_bus.dist_value   <= '0;
      pix_bus.start_of_map <= 1'b0;
    end else if (!pix_bus.valid || pix_bus.ready) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat = pending_pixels.pop_front();
        pix_bus.valid        <= 1'b1;
        pix_bus.dist_value   <= beat.dval;
        pix_bus.start_of_map <= beat.som;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // Cost receiver: random stalls, plus long hold-offs at fixed input counts
  int hold_left = 0;
  int in_seen = 0;
  always @(posedge clk) begin
    if (rst) begin
      cost_bus.ready <= 1'b0;
      hold_left <= 0;
      in_seen <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) in_seen <= in_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        cost_bus.ready <= 1'b0;
      end else if (pix_bus.valid && pix_bus.ready && (in_seen == 400 || in_seen == 1200)) begin
        hold_left <= 120;
        cost_bus.ready <= 1'b0;
      end else begin
        cost_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: track config, predict on each pixel beat, check each cost beat
  always @(posedge clk) begin : cost_checker
    cost_beat_t want;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          scca_pkg::REG_ROWS_IN_USE:      rows_eff = rows_effective(cfg_bus.data);
          scca_pkg::REG_NEIGHBOUR_WEIGHT: begin
            weight_eff = longint'(cfg_bus.data[scca_pkg::WEIGHT_W-1:0]);
            if (weight_eff > longint'(scca_pkg::WEIGHT_ONE)) begin
              weight_eff = longint'(scca_pkg::WEIGHT_ONE);
            end
          end
          default: ;
        endcase
      end
      if (pix_bus.valid && pix_bus.ready) begin
        expected_costs.insert(expected_costs.size(),
                              predict_cost(pix_bus.dist_value, pix_bus.start_of_map));
        pixels_accepted++;
      end
      if (cost_bus.valid && cost_bus.ready) begin
        if (expected_costs.size() == 0) begin
          $display("%0t: unexpected cost beat: cost %0d column_end %0b", $time,
                   cost_bus.cost, cost_bus.column_end);
          error_count++;
        end else begin
          want = expected_costs.pop_front();
          if (cost_bus.cost !== want.cost) begin
            $display("%0t: cost mismatch: expected %0d, actual %0d", $time,
                     want.cost, cost_bus.cost);
            error_count++;
          end
          if (cost_bus.column_end !== want.column_end) begin
            $display("%0t: column_end mismatch: expected %0b, actual %0b", $time,
                     want.column_end, cost_bus.column_end);
            error_count++;
          end
        end
      end
    end
  end

  // Queue one pixel and follow its row position
  task automatic add_pixel(input int d, input bit som);
    pixel_beat_t beat;
    if (need_start) begin
      som = 1'b1;
      need_start = 1'b0;
    end
    beat.dval = scca_pkg::dist_t'(d);
    beat.som = som;
    pending_pixels.insert(pending_pixels.size(), beat);
    pixels_queued++;
    if (som) begin
      gen_pos = 0;
      gen_first = 1'b1;
    end
    if (gen_pos >= gen_rows - 1) begin
      gen_pos = 0;
      gen_first = 1'b0;
    end else begin
      gen_pos++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixels_accepted != pixels_queued || expected_costs.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // A larger row count inside a map would read unwritten rows: force a new map
  task automatic write_reg(input logic [scca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scca_pkg::CFG_DATA_W-1:0] value);
    int new_rows;
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == scca_pkg::REG_ROWS_IN_USE) begin
      new_rows = rows_effective(value);
      if (new_rows > gen_rows && !gen_first) need_start = 1'b1;
      gen_rows = new_rows;
    end
  endtask

  task automatic begin_phase(input int rows, input int weight, input idle_mode_t mode);
    wait_drained();
    case (mode)
      SENDER_LIGHT: begin
        send_idle_pct <= 21;
        recv_idle_pct <= 49;
      end
      RECEIVER_LIGHT: begin
        send_idle_pct <= 49;
        recv_idle_pct <= 21;
      end
      default: begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
    endcase
    write_reg(scca_pkg::REG_ROWS_IN_USE, scca_pkg::CFG_DATA_W'(rows));
    write_reg(scca_pkg::REG_NEIGHBOUR_WEIGHT, scca_pkg::CFG_DATA_W'(weight));
  endtask

  function automatic int random_dist();
    int mode;
    int v;
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        v = $urandom_range(0, 3);
        case (v)
          0: return -128;
          1: return 127;
          2: return 0;
          default: return -1;
        endcase
      end
      1, 2: return $urandom_range(64, 127);
      3: begin
        v = $urandom_range(64, 128);
        return -v;
      end
      default: begin
        v = $urandom_range(0, 255);
        return v - 128;
      end
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) add_pixel(random_dist(), $urandom_range(0, 59) == 0);
  endtask

  // Stimulus and end of run
  initial begin
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = scca_pkg::REG_ROWS_IN_USE;
    cfg_bus.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: first column, top/middle/bottom rows, start mark mid-column
    begin_phase(3, scca_pkg::WEIGHT_ONE, SENDER_LIGHT);
    add_pixel(-128, 1'b1);
    add_pixel(127, 1'b0);
    add_pixel(0, 1'b0);
    add_pixel(127, 1'b0);
    add_pixel(-128, 1'b0);
    add_pixel(5, 1'b0);
    add_pixel(-1, 1'b0);
    add_pixel(64, 1'b1);
    add_pixel(-5, 1'b0);
    add_pixel(7, 1'b0);
    add_pixel(100, 1'b0);
    add_pixel(-100, 1'b0);

    // Row count shrunk with the column at row 2: that row closes it
    begin_phase(2, scca_pkg::WEIGHT_RESET, SENDER_LIGHT);
    add_pixel(-77, 1'b0);
    add_pixel(33, 1'b0);
    add_pixel(12, 1'b0);
    add_pixel(-128, 1'b0);
    add_pixel(127, 1'b0);

    // Climb to the cap; weight above one acts as one
    begin_phase(3, 300, SENDER_LIGHT);
    for (int i = 0; i < 150; i++) add_pixel($urandom_range(120, 127), i == 0);

    // Row count below the minimum, zero weight
    begin_phase(1, 0, SENDER_LIGHT);
    random_phase(50);

    begin_phase($urandom_range(5, 40), scca_pkg::WEIGHT_RESET, SENDER_LIGHT);
    random_phase(50);

    // Full-height column, row count above the maximum, then a partial column
    begin_phase(2047, $urandom_range(0, 256), RECEIVER_LIGHT);
    for (int i = 0; i < ROW_LIMIT + 20; i++) add_pixel(random_dist(), i == 0);

    // Shrink from row 20 of a full-height column
    begin_phase(7, scca_pkg::WEIGHT_ONE, RECEIVER_LIGHT);
    random_phase(40);

    begin_phase($urandom_range(2, 16), $urandom_range(0, 511), RECEIVER_LIGHT);
    random_phase(40);

    begin_phase($urandom_range(2, 16), $urandom_range(0, 511), NO_IDLE);
    random_phase(40);

    // Weight data wider than the register, row count zero
    begin_phase(0, 2047, NO_IDLE);
    random_phase(40);

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_costs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
